>>> src/stc_pkg.sv
// Shared types, codes and character helpers for the S-expression tokenizer.
package stc_pkg;

	// Offsets and lengths are tracked at this width internally.
	localparam int OFFSET_WIDTH = 16;
	localparam int OW = OFFSET_WIDTH;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// Scan modes.
	typedef enum logic [3:0] {
		MODE_IDLE    = 4'd0,
		MODE_IDENT   = 4'd1,
		MODE_NUMBER  = 4'd2,
		MODE_STRING  = 4'd3,
		MODE_EQ      = 4'd4,
		MODE_MINUS   = 4'd5,
		MODE_STAR    = 4'd6,
		MODE_AMP     = 4'd7,
		MODE_REFNAME = 4'd8,
		MODE_COMMENT = 4'd9
	} mode_t;

	// Token kinds.
	localparam logic [4:0] KIND_EOF     = 5'd0;
	localparam logic [4:0] KIND_IDENT   = 5'd1;
	localparam logic [4:0] KIND_NUMBER  = 5'd2;
	localparam logic [4:0] KIND_STRING  = 5'd3;
	localparam logic [4:0] KIND_SYMBOL  = 5'd4;
	localparam logic [4:0] KIND_LPAREN  = 5'd5;
	localparam logic [4:0] KIND_RPAREN  = 5'd6;
	localparam logic [4:0] KIND_EQEQ    = 5'd7;
	localparam logic [4:0] KIND_ARROW   = 5'd8;
	localparam logic [4:0] KIND_COMMENT = 5'd9;
	localparam logic [4:0] KIND_DOT     = 5'd10;
	localparam logic [4:0] KIND_COMMA   = 5'd11;
	localparam logic [4:0] KIND_PLUS    = 5'd12;
	localparam logic [4:0] KIND_MINUS   = 5'd13;
	localparam logic [4:0] KIND_SLASH   = 5'd14;
	localparam logic [4:0] KIND_STAR    = 5'd15;
	localparam logic [4:0] KIND_ASSIGN  = 5'd16;

	// Error codes.
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_UNTERM  = 2'd1;
	localparam logic [1:0] ERR_BAD_AMP = 2'd2;

	// Characters with a role of their own.
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;

	// One finished token.
	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [1:0]  err;
	} tok_t;

	// Results of one character: one or two tokens.
	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} run_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_alpha(c) || is_digit(c);
	endfunction

	// Limit an internal offset to the 16-bit output range.
	function automatic logic [15:0] sat16(input logic [OW-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		if (w > 33'h0FFFF)
			return 16'hFFFF;
		return w[15:0];
	endfunction

	function automatic tok_t mk_tok(input logic [4:0] kind, input logic [OW-1:0] start,
			input logic [OW-1:0] len, input logic [1:0] err);
		tok_t t;
		t.kind  = kind;
		t.start = sat16(start);
		t.len   = sat16(len);
		t.err   = err;
		return t;
	endfunction

endpackage

>>> src/stc_front.sv
// Front end: accepts characters, tracks scan mode and offsets, forms tokens.
module stc_front import stc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [7:0] ch,
	input  q_stat_t   q_stat,
	output logic      push,
	output run_t      push_run
);

	mode_t          mode_q, mode_n;
	logic [OW-1:0]  tstart_q, tstart_n;
	logic [OW-1:0]  coff_q;
	logic [OW-1:0]  span, span1;
	logic [OW:0]    span_inc, off_inc;
	logic [OW-1:0]  off_next;
	logic           first_emit, go_idle, idle_emit, idle_load, end_seen, accept, has_res;
	tok_t           first_tok, idle_tok;
	mode_t          idle_mode;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	// Span of the open token, plus saturating increments of the span and the offset.
	always_comb begin
		span     = (coff_q >= tstart_q) ? (coff_q - tstart_q) : '0;
		span_inc = {1'b0, span} + (OW+1)'(1);
		span1    = span_inc[OW] ? '1 : span_inc[OW-1:0];
		off_inc  = {1'b0, coff_q} + (OW+1)'(1);
		off_next = off_inc[OW] ? '1 : off_inc[OW-1:0];
	end

	// Handle the character as if no token were open.
	always_comb begin
		idle_emit = 1'b0;
		idle_load = 1'b0;
		idle_mode = MODE_IDLE;
		idle_tok  = mk_tok(KIND_EOF, coff_q, '0, ERR_NONE);
		if (ch == CH_NUL) begin
			idle_emit = 1'b1;
		end else if (!is_space(ch)) begin
			idle_load = 1'b1;
			if (is_alpha(ch)) begin
				idle_mode = MODE_IDENT;
			end else if (is_digit(ch)) begin
				idle_mode = MODE_NUMBER;
			end else begin
				unique case (ch)
					CH_QUOTE:  idle_mode = MODE_STRING;
					CH_EQUAL:  idle_mode = MODE_EQ;
					CH_MINUS:  idle_mode = MODE_MINUS;
					CH_STAR:   idle_mode = MODE_STAR;
					CH_AMP:    idle_mode = MODE_AMP;
					CH_SEMI:   idle_mode = MODE_COMMENT;
					CH_LPAREN: begin
						idle_emit = 1'b1;
						idle_tok  = mk_tok(KIND_LPAREN, coff_q, OW'(1), ERR_NONE);
					end
					CH_RPAREN: begin
						idle_emit = 1'b1;
						idle_tok  = mk_tok(KIND_RPAREN, coff_q, OW'(1), ERR_NONE);
					end
					CH_DOT: begin
						idle_emit = 1'b1;
						idle_tok  = mk_tok(KIND_DOT, coff_q, OW'(1), ERR_NONE);
					end
					CH_COMMA: begin
						idle_emit = 1'b1;
						idle_tok  = mk_tok(KIND_COMMA, coff_q, OW'(1), ERR_NONE);
					end
					CH_PLUS: begin
						idle_emit = 1'b1;
						idle_tok  = mk_tok(KIND_PLUS, coff_q, OW'(1), ERR_NONE);
					end
					CH_SLASH: begin
						idle_emit = 1'b1;
						idle_tok  = mk_tok(KIND_SLASH, coff_q, OW'(1), ERR_NONE);
					end
					default: begin
						idle_emit = 1'b1;
						idle_tok  = mk_tok(KIND_SYMBOL, coff_q, OW'(1), ERR_NONE);
					end
				endcase
			end
		end
	end

	// Close or extend the open token.
	always_comb begin
		first_emit = 1'b0;
		first_tok  = mk_tok(KIND_IDENT, tstart_q, span, ERR_NONE);
		go_idle    = 1'b0;
		mode_n     = mode_q;
		tstart_n   = tstart_q;
		unique case (mode_q)
			MODE_IDENT: begin
				if (!(is_alnum(ch) || ch == CH_UNDER || ch == CH_STAR || ch == CH_AMP ||
						ch == CH_DOT)) begin
					first_emit = 1'b1;
					go_idle    = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (!(is_digit(ch) || ch == CH_DOT)) begin
					first_emit = 1'b1;
					first_tok  = mk_tok(KIND_NUMBER, tstart_q, span, ERR_NONE);
					go_idle    = 1'b1;
				end
			end
			MODE_STRING: begin
				if (ch == CH_QUOTE) begin
					first_emit = 1'b1;
					first_tok  = mk_tok(KIND_STRING, tstart_q, span1, ERR_NONE);
					mode_n     = MODE_IDLE;
				end else if (ch == CH_NUL) begin
					first_emit = 1'b1;
					first_tok  = mk_tok(KIND_STRING, tstart_q, span, ERR_UNTERM);
					go_idle    = 1'b1;
				end
			end
			MODE_EQ: begin
				first_emit = 1'b1;
				if (ch == CH_EQUAL) begin
					first_tok = mk_tok(KIND_EQEQ, tstart_q, OW'(2), ERR_NONE);
					mode_n    = MODE_IDLE;
				end else begin
					first_tok = mk_tok(KIND_ASSIGN, tstart_q, OW'(1), ERR_NONE);
					go_idle   = 1'b1;
				end
			end
			MODE_MINUS: begin
				first_emit = 1'b1;
				if (ch == CH_GT) begin
					first_tok = mk_tok(KIND_ARROW, tstart_q, OW'(2), ERR_NONE);
					mode_n    = MODE_IDLE;
				end else begin
					first_tok = mk_tok(KIND_MINUS, tstart_q, OW'(1), ERR_NONE);
					go_idle   = 1'b1;
				end
			end
			MODE_STAR: begin
				if (is_alpha(ch)) begin
					mode_n = MODE_REFNAME;
				end else begin
					first_emit = 1'b1;
					first_tok  = mk_tok(KIND_STAR, tstart_q, OW'(1), ERR_NONE);
					go_idle    = 1'b1;
				end
			end
			MODE_AMP: begin
				if (is_alpha(ch)) begin
					mode_n = MODE_REFNAME;
				end else begin
					first_emit = 1'b1;
					first_tok  = mk_tok(KIND_SYMBOL, tstart_q, OW'(1), ERR_BAD_AMP);
					go_idle    = 1'b1;
				end
			end
			MODE_REFNAME: begin
				if (!(is_alnum(ch) || ch == CH_UNDER)) begin
					first_emit = 1'b1;
					go_idle    = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (ch == CH_NEWLINE || ch == CH_NUL) begin
					first_emit = 1'b1;
					first_tok  = mk_tok(KIND_COMMENT, tstart_q, span, ERR_NONE);
					go_idle    = 1'b1;
				end
			end
			default: go_idle = 1'b1;
		endcase
		if (go_idle) begin
			mode_n = idle_mode;
			if (idle_load)
				tstart_n = coff_q;
		end
	end

	// Pack results of this character for the queue.
	always_comb begin
		end_seen     = go_idle && (ch == CH_NUL);
		has_res      = first_emit || (go_idle && idle_emit);
		push         = accept && has_res;
		push_run.two = first_emit && go_idle && idle_emit;
		push_run.t0  = first_emit ? first_tok : idle_tok;
		push_run.t1  = idle_tok;
	end

	// Advance scan state on each transfer; end of text restarts the offsets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			tstart_q <= '0;
			coff_q   <= '0;
		end else if (accept) begin
			if (end_seen) begin
				mode_q   <= MODE_IDLE;
				tstart_q <= '0;
				coff_q   <= '0;
			end else begin
				mode_q   <= mode_n;
				tstart_q <= tstart_n;
				coff_q   <= off_next;
			end
		end
	end

endmodule

>>> src/stc_queue.sv
// Short queue of per-character result runs between front and back.
module stc_queue import stc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  run_t    push_run,
	input  logic    pop,
	output run_t    head,
	output q_stat_t q_stat
);

	run_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);

	// Store entries.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_run;
	end

	// Advance pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QAW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

endmodule

>>> src/stc_back.sv
// Back end: serializes queued runs into single results through an output register.
module stc_back import stc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  run_t        head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  kind,
	output logic [15:0] start_offset,
	output logic [15:0] length,
	output logic [1:0]  error_code,
	output logic        last_of_run
);

	logic half_q, out_valid_q, load, take, is_last;
	tok_t sel, tok_q;
	logic last_q;

	// Pick the pending token of the head run.
	always_comb begin
		load    = !out_valid_q || !out_stall;
		take    = load && !q_stat.empty;
		sel     = half_q ? head.t1 : head.t0;
		is_last = !head.two || half_q;
		pop     = take && is_last;
	end

	// Track which half of the head run goes next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_stat.empty;
			if (take)
				half_q <= !is_last;
		end
	end

	// Hold the result payload until its transfer.
	always_ff @(posedge clk) begin
		if (take) begin
			tok_q  <= sel;
			last_q <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = tok_q.kind;
	assign start_offset = tok_q.start;
	assign length       = tok_q.len;
	assign error_code   = tok_q.err;
	assign last_of_run  = last_q;

endmodule

>>> src/sexpr_char_tokenizer_top.sv
// Top level of the S-expression character tokenizer.
// Input channel: one text byte on ch per transfer (in_valid / in_stall); a byte
//   of zero ends the text and restarts offsets at zero for the next text.
// Output channel: one token per transfer (out_valid / out_stall) with kind,
//   start_offset, length, error_code and last_of_run, which marks the final
//   token caused by one input byte (a byte yields zero, one or two tokens).
// Throughput: one byte per cycle while in_stall is low; the scan mode update in
//   the front end is combinational. A byte that yields two tokens occupies the output
//   for two transfers, so sustained rate is set by the single output register.
// Path: a token is registered in the four-entry run queue and then in the output
//   register before it is shown.
// Stall: when out_stall holds, results collect in the run queue; once it is
//   full, in_stall rises until the back end drains an entry.
// Reset: arst_n clears scan mode, offsets, queue and output valid at once.
module sexpr_char_tokenizer_top import stc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  kind,
	output logic [15:0] start_offset,
	output logic [15:0] length,
	output logic [1:0]  error_code,
	output logic        last_of_run
);

	q_stat_t q_stat;
	logic    push, pop;
	run_t    push_run, head;

	stc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.q_stat   (q_stat),
		.push     (push),
		.push_run (push_run)
	);

	stc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	stc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.start_offset (start_offset),
		.length       (length),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

endmodule

>>> src/stc_checker.sv
// Port-level checks for the tokenizer, bound to the top level.
module stc_checker import stc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  kind,
	input logic [15:0] start_offset,
	input logic [15:0] length,
	input logic [1:0]  error_code,
	input logic        last_of_run
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(kind) && $stable(start_offset) &&
			$stable(length) && $stable(error_code) && $stable(last_of_run))
		else $error("output payload changed while stalled");

	// Errors only come with their matching token kind.
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |->
			(error_code == ERR_UNTERM && kind == KIND_STRING) ||
			(error_code == ERR_BAD_AMP && kind == KIND_SYMBOL && length == 16'd1))
		else $error("error code on wrong token kind");

	// End of text is empty and closes its run.
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EOF |-> length == 16'd0 && last_of_run &&
			error_code == ERR_NONE)
		else $error("malformed end-of-text token");

	// An unterminated string is always followed by end of text.
	a_unterm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_UNTERM |-> !last_of_run)
		else $error("unterminated string closed its run");

endmodule

bind sexpr_char_tokenizer_top stc_checker u_chk (.*);
